/* src/median_filter_3x3_macros.svh */
// Assertion helpers for the median filter; clk and arst_n come from the using scope.
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// same-cycle implication
`define MF3_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mf3_pkg.sv */
package mf3_pkg;

	localparam int PIX_W        = 8;
	localparam int ROW_W        = 12;
	localparam int COL_W        = 10;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int HEIGHT_MAX   = 4096;
	localparam int SIZE_MIN     = 3;
	localparam int WIN_N        = 9;
	localparam int RES_N        = 4;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// result slots of one pixel, in emission order
	localparam int RES_CENTER = 0;
	localparam int RES_RIGHT  = 1;
	localparam int RES_BOTTOM = 2;
	localparam int RES_CORNER = 3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WIN_N-1:0] win_t;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// what one pixel releases: pending results and their coordinates
	typedef struct packed {
		logic [RES_N-1:0] mask;
		logic             med_en;
		logic [ROW_W-1:0] row_a;
		logic [COL_W-1:0] col_a;
		logic [ROW_W-1:0] row_b;
		logic [COL_W-1:0] col_b;
	} res_info_t;

endpackage

/* src/mf3_line_mem.sv */
module mf3_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data_q,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

/* src/mf3_median.sv */
module mf3_median
	import mf3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  win_t      in_win,
	input  res_info_t in_info,
	output logic      out_valid,
	input  logic      out_ready,
	output pix_t      out_median,
	output res_info_t out_info
);

	function automatic win_t cx(win_t p, int a, int b);
		win_t r;
		r = p;
		if (p[a] > p[b]) begin
			r[a] = p[b];
			r[b] = p[a];
		end
		return r;
	endfunction

	logic      v_s2, v_s3, v_s4;
	logic      en_s2, en_s3, en_s4;
	win_t      win_s2, win_s3, win_s4;
	res_info_t info_s2, info_s3, info_s4;
	win_t      net_a, net_b, net_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	// network split into three groups of three layers
	always_comb begin
		net_a = win_s2;
		net_a = cx(net_a, 1, 2); net_a = cx(net_a, 4, 5); net_a = cx(net_a, 7, 8);
		net_a = cx(net_a, 0, 1); net_a = cx(net_a, 3, 4); net_a = cx(net_a, 6, 7);
		net_a = cx(net_a, 1, 2); net_a = cx(net_a, 4, 5); net_a = cx(net_a, 7, 8);

		net_b = win_s3;
		net_b = cx(net_b, 0, 3); net_b = cx(net_b, 5, 8); net_b = cx(net_b, 4, 7);
		net_b = cx(net_b, 3, 6); net_b = cx(net_b, 1, 4); net_b = cx(net_b, 2, 5);
		net_b = cx(net_b, 4, 7);

		net_c = win_s4;
		net_c = cx(net_c, 2, 4);
		net_c = cx(net_c, 4, 6);
		net_c = cx(net_c, 2, 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= in_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			win_s2  <= in_win;
			info_s2 <= in_info;
		end
		if (en_s3) begin
			win_s3  <= net_a;
			info_s3 <= info_s2;
		end
		if (en_s4) begin
			win_s4  <= net_b;
			info_s4 <= info_s3;
		end
	end

	assign out_valid  = v_s4;
	assign out_median = net_c[4];
	assign out_info   = info_s4;

endmodule

/* src/mf3_out_seq.sv */
module mf3_out_seq
	import mf3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pix_t             in_median,
	input  res_info_t        in_info,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] median_value,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             frame_last
);

	logic [RES_N-1:0] mask_q;
	res_info_t        info_q;
	pix_t             val_q;
	logic [RES_N-1:0] mask_rest;
	logic [RES_N-1:0] pick;

	assign mask_rest = mask_q & (mask_q - RES_N'(1));
	assign pick      = mask_q & ~mask_rest;
	assign out_valid = |mask_q;
	// take the next word once the last pending result leaves
	assign in_ready  = (mask_rest == '0) && ((mask_q == '0) || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (in_valid && in_ready) begin
			mask_q <= in_info.mask;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			info_q <= in_info;
			val_q  <= in_info.med_en ? in_median : '0;
		end
	end

	always_comb begin
		median_value = '0;
		out_row      = info_q.row_b;
		out_col      = info_q.col_b;
		frame_last   = 1'b0;
		if (pick[RES_CENTER]) begin
			median_value = val_q;
			out_row      = info_q.row_a;
			out_col      = info_q.col_a;
		end else if (pick[RES_RIGHT]) begin
			out_row = info_q.row_a;
		end else if (pick[RES_BOTTOM]) begin
			out_col = info_q.col_a;
		end else begin
			frame_last = pick[RES_CORNER];
		end
	end

endmodule

/* src/median_filter_3x3.sv */
// 3x3 median filter for 8-bit grayscale pixels streamed in raster order.
// Pixel channel: pixel with pixel_valid / pixel_ready, one word per pixel.
// Result channel: median_value, out_row, out_col, frame_last with
// result_valid / result_ready. Each pixel releases zero to four results:
// the pixel one row up and one column left (median inside, zero on the
// border), and zero results for the right column and bottom row.
// frame_last marks the bottom-right result of the image.
// Config: cfg_we / cfg_index / cfg_data write image_width (index 0) and
// image_height (index 1); write them only while the stream is idle.
// A pixel's first result passes the line store read, then three stages of the
// compare-exchange network, then the result register of the output sequencer.
// Throughput: one pixel per clock while each pixel releases at most one result
// and result_ready stays high; a pixel releasing more holds the input until
// its last result leaves, as the result register drains one word per clock.
// Reset: size returns to 640 x 480 and position to row 0, column 0. The
// line store is not cleared; stale words reach only windows with zeroed medians.
// When the receiver stalls, the four pipeline stages fill up and then
// pixel_ready drops until results are taken again.
`include "median_filter_3x3_macros.svh"

module median_filter_3x3
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [PIX_W-1:0]      median_value,
	output logic [ROW_W-1:0]      out_row,
	output logic [COL_W-1:0]      out_col,
	output logic                  frame_last
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int WIN_Q = WIN_N - 3;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WW-1:0]           w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             wrap_c;
	logic [CW-1:0]    c0;
	logic [ROW_W:0]   r_pre;
	logic [ROW_W-1:0] r0;
	logic [CW:0]      c_inc;
	logic [ROW_W:0]   r_inc;
	logic             last_col, last_row;
	res_info_t        info_0;

	logic             pixel_accept;
	logic             v_s1;
	logic             s1_adv;
	pix_t             px_s1;
	logic [CW-1:0]    c_s1;
	res_info_t        info_s1;
	logic [2*PIX_W-1:0] rd_data_q;
	pix_t             top, mid;
	pix_t [WIN_Q-1:0] win_q;
	win_t             win;

	logic             med_ready;
	logic             med_valid;
	pix_t             med_value;
	res_info_t        med_info;
	logic             seq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_REG_W'(SIZE_MIN)) begin
			w_eff = WW'(SIZE_MIN);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < HEIGHT_REG_W'(SIZE_MIN)) begin
			h_eff = HEIGHT_REG_W'(SIZE_MIN);
		end else if (height_q > HEIGHT_REG_W'(HEIGHT_MAX)) begin
			h_eff = HEIGHT_REG_W'(HEIGHT_MAX);
		end else begin
			h_eff = height_q;
		end
	end

	// position of the incoming pixel; wraps here too in case the size shrank
	always_comb begin
		wrap_c   = (CW+1)'(col_q) >= (CW+1)'(w_eff);
		c0       = wrap_c ? '0 : col_q;
		r_pre    = (ROW_W+1)'(row_q) + (ROW_W+1)'(wrap_c);
		r0       = (r_pre >= (ROW_W+1)'(h_eff)) ? '0 : r_pre[ROW_W-1:0];
		c_inc    = (CW+1)'(c0) + (CW+1)'(1);
		r_inc    = (ROW_W+1)'(r0) + (ROW_W+1)'(1);
		last_col = c_inc >= (CW+1)'(w_eff);
		last_row = r_inc >= (ROW_W+1)'(h_eff);

		info_0.mask[RES_CENTER] = (r0 != '0) && (c0 != '0);
		info_0.mask[RES_RIGHT]  = (r0 != '0) && last_col;
		info_0.mask[RES_BOTTOM] = last_row && (c0 != '0);
		info_0.mask[RES_CORNER] = last_row && last_col;
		info_0.med_en = (r0 >= ROW_W'(2)) && (c0 >= CW'(2));
		info_0.row_a  = r0 - ROW_W'(1);
		info_0.col_a  = COL_W'(c0 - CW'(1));
		info_0.row_b  = ROW_W'(h_eff - HEIGHT_REG_W'(1));
		info_0.col_b  = COL_W'(w_eff - WW'(1));
	end

	assign s1_adv       = v_s1 && med_ready;
	assign pixel_ready  = !v_s1 || med_ready;
	assign pixel_accept = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
			win_q <= '0;
		end else begin
			if (pixel_ready) begin
				v_s1 <= pixel_valid;
			end
			if (pixel_accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : r_inc[ROW_W-1:0];
				end else begin
					col_q <= c_inc[CW-1:0];
					row_q <= r0;
				end
			end
			if (s1_adv) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top;
				win_q[4] <= mid;
				win_q[5] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			px_s1   <= pixel;
			c_s1    <= c0;
			info_s1 <= info_0;
		end
	end

	// word holds {upper row, middle row} of one column
	mf3_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW),
		.DW   (2 * PIX_W)
	) u_line_mem (
		.clk      (clk),
		.rd_en    (pixel_accept),
		.rd_addr  (c0),
		.rd_data_q(rd_data_q),
		.wr_en    (s1_adv),
		.wr_addr  (c_s1),
		.wr_data  ({mid, px_s1})
	);

	assign top = rd_data_q[2*PIX_W-1:PIX_W];
	assign mid = rd_data_q[PIX_W-1:0];

	always_comb begin
		win[0] = win_q[0];
		win[1] = win_q[1];
		win[2] = win_q[2];
		win[3] = win_q[3];
		win[4] = win_q[4];
		win[5] = win_q[5];
		win[6] = top;
		win[7] = mid;
		win[8] = px_s1;
	end

	mf3_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (med_ready),
		.in_win    (win),
		.in_info   (info_s1),
		.out_valid (med_valid),
		.out_ready (seq_ready),
		.out_median(med_value),
		.out_info  (med_info)
	);

	mf3_out_seq u_out_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (med_valid),
		.in_ready    (seq_ready),
		.in_median   (med_value),
		.in_info     (med_info),
		.out_valid   (result_valid),
		.out_ready   (result_ready),
		.median_value(median_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.frame_last  (frame_last)
	);

	`MF3_ASSERT_IMPL(a_line_rw_apart, s1_adv && pixel_accept, c_s1 != c0, "line store read and write on one column")
	`MF3_ASSERT_IMPL(a_s1_no_overrun, pixel_accept && v_s1, s1_adv, "stage one overwritten before moving on")
	`MF3_ASSERT_IMPL(a_median_interior, result_valid && (median_value != '0), (out_row != '0) && (out_col != '0), "nonzero median on border")

endmodule
